// ===== hdl/page_turn_button_gesture_decoder_macros.svh =====
// Assertion macros shared by the checker of the page-turn decoder.
`ifndef PAGE_TURN_BUTTON_GESTURE_DECODER_MACROS_SVH
`define PAGE_TURN_BUTTON_GESTURE_DECODER_MACROS_SVH

// Implication checked every cycle outside reset.
`define PTBGD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptbgd assertion failed");

// Next-cycle implication checked outside reset.
`define PTBGD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptbgd assertion failed");

// Condition that must hold in the cycle after reset is applied.
`define PTBGD_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("ptbgd assertion failed");

`endif

// ===== hdl/ptbgd_pkg.sv =====
`default_nettype none

package ptbgd_pkg;

   // field widths
   localparam int TIME_W      = 32;
   localparam int ACTION_W    = 3;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int HOLD_W      = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_US  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TIME_US = 2'd2;

   // register reset values
   localparam logic [TIME_W-1:0] DEBOUNCE_US_RESET  = 32'd50000;
   localparam logic [TIME_W-1:0] HOLD_TIME_US_RESET = 32'd500000;

   // long-hold counter saturates here
   localparam logic [HOLD_W-1:0] HOLD_MAX = 2'd2;

   // key action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE  = 3'd0,
      ACT_PGDN  = 3'd1,
      ACT_PGUP2 = 3'd2,
      ACT_CHOME = 3'd3,
      ACT_CEND  = 3'd4,
      ACT_PGUP  = 3'd5
   } action_type;

   typedef struct packed {
      logic              enable;
      logic [TIME_W-1:0] debounce_us;
      logic [TIME_W-1:0] hold_time_us;
   } cfg_type;

   typedef struct packed {
      logic       level_changed;
      logic       led_on;
      action_type key_action;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/ptbgd_csr.sv =====
`default_nettype none

module ptbgd_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire  [ptbgd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [ptbgd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output ptbgd_pkg::cfg_type                  cfg
);

   ptbgd_pkg::cfg_type cfg_ff;

   // register file, writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.debounce_us  <= ptbgd_pkg::DEBOUNCE_US_RESET;
         cfg_ff.hold_time_us <= ptbgd_pkg::HOLD_TIME_US_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ptbgd_pkg::CSR_ENABLE:       cfg_ff.enable       <= csr_wdata[0];
            ptbgd_pkg::CSR_DEBOUNCE_US:  cfg_ff.debounce_us  <= csr_wdata;
            ptbgd_pkg::CSR_HOLD_TIME_US: cfg_ff.hold_time_us <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/ptbgd_core.sv =====
`default_nettype none

module ptbgd_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              fire,
   input  wire  [ptbgd_pkg::TIME_W-1:0]     now_us,
   input  wire                              pin_level,
   input  ptbgd_pkg::cfg_type               cfg,
   output ptbgd_pkg::result_type            result
);

   logic                          button_level_ff, button_level_in;
   logic [ptbgd_pkg::TIME_W-1:0]  press_time_ff, press_time_in;
   logic [ptbgd_pkg::TIME_W-1:0]  release_time_ff, release_time_in;
   logic [ptbgd_pkg::TIME_W-1:0]  repeat_time_ff, repeat_time_in;
   logic                          tap_count_ff, tap_count_in;
   logic [ptbgd_pkg::HOLD_W-1:0]  hold_count_ff, hold_count_in;
   logic                          led_state_ff, led_state_in;

   logic [ptbgd_pkg::TIME_W-1:0]  since_press;
   logic [ptbgd_pkg::TIME_W-1:0]  since_release;
   logic [ptbgd_pkg::TIME_W-1:0]  since_repeat;
   logic                          sampling;
   logic                          changed;
   logic                          repeat_tick;
   ptbgd_pkg::action_type         action;

   // wrapping time differences
   assign since_press   = now_us - press_time_ff;
   assign since_release = now_us - release_time_ff;
   assign since_repeat  = now_us - repeat_time_ff;

   assign sampling = cfg.enable && (since_press > cfg.debounce_us);
   assign changed  = sampling && (pin_level != button_level_ff);
   // a fresh press restarts the repeat timer, so a tick only comes while held
   assign repeat_tick = sampling && !changed && !button_level_ff &&
                        (since_repeat > cfg.hold_time_us);

   // next state and result
   always_comb begin
      button_level_in = button_level_ff;
      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      repeat_time_in  = repeat_time_ff;
      tap_count_in    = tap_count_ff;
      hold_count_in   = hold_count_ff;
      led_state_in    = led_state_ff;
      action          = ptbgd_pkg::ACT_NONE;

      if (changed) begin
         button_level_in = pin_level;
         led_state_in    = !pin_level;
         hold_count_in   = '0;
         if (!pin_level) begin
            press_time_in  = now_us;
            repeat_time_in = now_us;
         end else begin
            if (since_press < cfg.hold_time_us) begin
               tap_count_in = !(since_release > cfg.hold_time_us);
            end
            release_time_in = now_us;
            if (hold_count_ff == '0) begin
               action = tap_count_in ? ptbgd_pkg::ACT_PGUP2 : ptbgd_pkg::ACT_PGDN;
            end
         end
      end

      if (repeat_tick) begin
         repeat_time_in = repeat_time_ff + cfg.hold_time_us;
         led_state_in   = !led_state_ff;
         if (hold_count_ff < ptbgd_pkg::HOLD_MAX) begin
            hold_count_in = hold_count_ff + 2'd1;
         end
         if (hold_count_in == 2'd1) begin
            action = tap_count_ff ? ptbgd_pkg::ACT_CEND : ptbgd_pkg::ACT_CHOME;
         end else begin
            action = tap_count_ff ? ptbgd_pkg::ACT_PGUP : ptbgd_pkg::ACT_PGDN;
         end
      end
   end

   // gesture state, updated once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         button_level_ff <= 1'b1;
         press_time_ff   <= '0;
         release_time_ff <= '0;
         repeat_time_ff  <= '0;
         tap_count_ff    <= 1'b0;
         hold_count_ff   <= '0;
         led_state_ff    <= 1'b0;
      end else if (fire) begin
         button_level_ff <= button_level_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
         repeat_time_ff  <= repeat_time_in;
         tap_count_ff    <= tap_count_in;
         hold_count_ff   <= hold_count_in;
         led_state_ff    <= led_state_in;
      end
   end

   assign result.key_action    = action;
   assign result.led_on        = led_state_in;
   assign result.level_changed = changed;

endmodule

`default_nettype wire

// ===== hdl/page_turn_button_gesture_decoder.sv =====
// Page-turn button gesture decoder.
// Request channel (req_*): one poll of the active-low button per request,
// carrying the microsecond timestamp and the sampled pin level.
// Response channel (rsp_*): exactly one response per request, in order,
// with the key action, the LED state and a debounced-level-change flag.
// Configuration (csr_*): enable, debounce time and long-press time, written
// at any edge where csr_we is high; write only while no request is in flight.
// Path: the request is captured in the input register, then the decode
// logic feeds the response register.
// Throughput: one request per cycle while rsp_tready stays high; the gesture
// state is read and updated in the decode step, which sets the rate.
// Stall: while rsp_tready is low the response register holds; one more
// request is still taken into an empty input register, after that req_tready
// drops until the response is taken.
// Reset: synchronous; clears both pipeline stages, returns the button to
// released, the LED to off, and the registers to their default values.
`default_nettype none

module page_turn_button_gesture_decoder (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [31:0] now_us, [32] pin_level, [39:33] zero
   input  wire  [ptbgd_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [2:0] key_action, [3] led_on, [4] level_changed, [7:5] zero
   output logic [ptbgd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                                 csr_we,
   input  wire  [ptbgd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [ptbgd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   ptbgd_pkg::cfg_type            cfg;
   ptbgd_pkg::result_type         result;

   logic                          in_valid_ff, in_valid_in;
   logic [ptbgd_pkg::TIME_W-1:0]  in_now_ff;
   logic                          in_pin_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   ptbgd_pkg::result_type         rsp_data_ff;
   logic                          req_accept;
   logic                          advance;

   // pipeline flow control
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_now_ff <= req_tdata[ptbgd_pkg::TIME_W-1:0];
         in_pin_ff <= req_tdata[ptbgd_pkg::TIME_W];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   ptbgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptbgd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .now_us    (in_now_ff),
      .pin_level (in_pin_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

`default_nettype wire

// ===== hdl/ptbgd_checker.sv =====
`default_nettype none
`include "page_turn_button_gesture_decoder_macros.svh"

module ptbgd_checker (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tready,
   input  wire                                 rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire  [ptbgd_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic [ptbgd_pkg::ACTION_W-1:0] act;
   logic                           led;
   logic                           chg;
   logic                           held_act;

   assign act = rsp_tdata[2:0];
   assign led = rsp_tdata[3];
   assign chg = rsp_tdata[4];

   // actions that only a long-hold tick produces
   assign held_act = (act == ptbgd_pkg::ACT_CHOME) || (act == ptbgd_pkg::ACT_CEND) ||
                     (act == ptbgd_pkg::ACT_PGUP);

   // no stale response survives reset
   `PTBGD_ASSERT_AFTER_RESET(a_reset_empty, !rsp_tvalid && req_tready)

   // a stalled response keeps its contents
   `PTBGD_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a double-tap action only comes with a release, which puts the LED out
   `PTBGD_ASSERT_IMP(a_tap_on_release, rsp_tvalid && (act == ptbgd_pkg::ACT_PGUP2), chg && !led)

   // a long-hold action never comes with a level change
   `PTBGD_ASSERT_IMP(a_hold_no_change, rsp_tvalid && held_act, !chg)

endmodule

bind page_turn_button_gesture_decoder ptbgd_checker u_ptbgd_checker (.*);

`default_nettype wire

// ===== tb/tb_page_turn_button_gesture_decoder.sv =====
`default_nettype none

module tb_page_turn_button_gesture_decoder;
   import ptbgd_pkg::*;

   localparam int          SETTLE_CYCLES = 4;     // two-stage pipeline plus margin
   localparam int          QUIET_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int          CHUNK_POLLS   = 43;    // minimum requests per enabled setting
   localparam int          MAX_REPORTS   = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;  // unmapped register index

   typedef enum logic {ROW_POLL, ROW_REG} row_kind;
   typedef enum {SET_TYPICAL, SET_EDGE_LOW, SET_LONG_MAX, SET_WIDE, SET_DISABLED}
      setting_kind;

   typedef struct {
      row_kind                kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [TIME_W-1:0]      value;   // timestamp for a poll, data for a write
      logic                   pin;
      logic                   typed;   // want is fixed by hand
      result_type             want;
   } script_row;

   typedef struct {
      logic       typed;
      result_type want;
   } fixed_answer;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   wire                     req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   wire                     rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_ENABLE;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // gesture state mirror, reset values
   cfg_type             cfg = '{enable: 1'b0, debounce_us: DEBOUNCE_US_RESET,
                                hold_time_us: HOLD_TIME_US_RESET};
   logic                btn_level  = 1'b1;
   logic [TIME_W-1:0]   t_press    = '0;
   logic [TIME_W-1:0]   t_release  = '0;
   logic [TIME_W-1:0]   t_tick     = '0;
   logic                second_tap = 1'b0;
   logic [HOLD_W-1:0]   hold_ticks = '0;
   logic                led_lit    = 1'b0;

   result_type          reports_due[$];
   fixed_answer         fixed_answers[$];
   script_row           script[$];
   logic [TIME_W-1:0]   stamp;
   int unsigned         gap_pct = 0;
   int unsigned         stall_pct = 0;
   int unsigned         polls_sent = 0;
   int unsigned         responses_checked = 0;
   int unsigned         actions_seen = 0;
   int unsigned         reg_writes = 0;
   int unsigned         mismatches = 0;
   int unsigned         quiet_cycles = 0;

   int unsigned         gap_plan[4]   = '{0, 87, 0, 36};
   int unsigned         stall_plan[4] = '{0, 0, 87, 36};
   setting_kind         plan[12] = '{SET_TYPICAL, SET_EDGE_LOW, SET_TYPICAL,
                                     SET_WIDE, SET_TYPICAL, SET_LONG_MAX,
                                     SET_TYPICAL, SET_DISABLED, SET_TYPICAL,
                                     SET_WIDE, SET_TYPICAL, SET_EDGE_LOW};

   page_turn_button_gesture_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // one poll of the button through the gesture state; all time math mod 2^32
   function automatic result_type decode_poll(input logic [TIME_W-1:0] now,
                                              input logic pin);
      result_type        r;
      logic [TIME_W-1:0] since_press;
      logic [TIME_W-1:0] since_tick;
      r.key_action    = ACT_NONE;
      r.level_changed = 1'b0;
      since_press     = now - t_press;
      if (cfg.enable && since_press > cfg.debounce_us) begin
         if (pin != btn_level) begin
            r.level_changed = 1'b1;
            btn_level       = pin;
            led_lit         = ~pin;
            if (!pin) begin
               t_press = now;
               t_tick  = now;
            end else begin
               // a short press decides single or double tap
               if (since_press < cfg.hold_time_us)
                  second_tap = ((now - t_release) <= cfg.hold_time_us);
               t_release = now;
               if (hold_ticks == '0)
                  r.key_action = second_tap ? ACT_PGUP2 : ACT_PGDN;
            end
            hold_ticks = '0;
         end
         since_tick = now - t_tick;
         // held: first tick jumps to an end, later ticks auto-repeat
         if (!btn_level && since_tick > cfg.hold_time_us) begin
            t_tick  = t_tick + cfg.hold_time_us;
            led_lit = ~led_lit;
            if (hold_ticks < HOLD_MAX)
               hold_ticks = hold_ticks + 1'b1;
            if (hold_ticks == 2'd1)
               r.key_action = second_tap ? ACT_CEND : ACT_CHOME;
            else
               r.key_action = second_tap ? ACT_PGUP : ACT_PGDN;
         end
      end
      r.led_on = led_lit;
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] span(input longint unsigned lo,
                                              input longint unsigned hi);
      longint unsigned pick;
      if (hi <= lo)
         return 32'(lo);
      pick = {$urandom, $urandom};
      return 32'(lo + pick % (hi - lo + 1));
   endfunction

   function automatic script_row row_poll(input logic [TIME_W-1:0] now, input logic pin);
      script_row r;
      r.kind  = ROW_POLL;
      r.index = CSR_ENABLE;
      r.value = now;
      r.pin   = pin;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic script_row row_check(input logic [TIME_W-1:0] now, input logic pin,
                                           input action_type act, input logic led,
                                           input logic chg);
      script_row r;
      r                    = row_poll(now, pin);
      r.typed              = 1'b1;
      r.want.key_action    = act;
      r.want.led_on        = led;
      r.want.level_changed = chg;
      return r;
   endfunction

   function automatic script_row row_reg(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [TIME_W-1:0] value);
      script_row r;
      r       = row_poll(value, 1'b1);
      r.kind  = ROW_REG;
      r.index = idx;
      return r;
   endfunction

   // register write, only once every request in flight has answered
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      req_tvalid <= 1'b0;
      while (responses_checked < polls_sent)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ENABLE:       cfg.enable       = value[0];
         CSR_DEBOUNCE_US:  cfg.debounce_us  = value;
         CSR_HOLD_TIME_US: cfg.hold_time_us = value;
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_poll(input logic [TIME_W-1:0] now, input logic pin,
                            input logic typed, input result_type want);
      fixed_answer note;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      note.typed = typed;
      note.want  = want;
      fixed_answers.push_back(note);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-TIME_W-1){1'b0}}, pin, now};
      do @(posedge clock); while (!req_tready);
      polls_sent++;
   endtask

   task automatic step_poll(input logic [TIME_W-1:0] step, input logic pin);
      stamp = stamp + step;
      send_poll(stamp, pin, 1'b0, '0);
   endtask

   task automatic apply_setting(input setting_kind sk);
      logic [TIME_W-1:0] db;
      logic [TIME_W-1:0] lp;
      db = $urandom_range(0, 400);
      lp = $urandom_range(300, 4000);
      case (sk)
         SET_EDGE_LOW: begin
            db = '0;
            lp = 32'd1;
         end
         SET_LONG_MAX: lp = '1;
         SET_WIDE: begin
            db = $urandom;
            lp = $urandom | 32'd1;
         end
         default: ;
      endcase
      write_reg(CSR_DEBOUNCE_US, db);
      write_reg(CSR_HOLD_TIME_US, lp);
      // junk above bit 0 of the enable write must be dropped
      write_reg(CSR_ENABLE, ($urandom & 32'hFFFF_FFFE) | (sk != SET_DISABLED));
   endtask

   // a gesture as a person makes it, timed against the current setting
   task automatic play_gesture();
      longint unsigned db;
      longint unsigned lp;
      int unsigned     pick;
      db   = cfg.debounce_us;
      lp   = cfg.hold_time_us;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         // one or two taps, with contact bounce after each press, mostly inside the debounce window
         repeat ((pick < 35) ? 1 : 2) begin
            step_poll(span(db + 1, db + lp), 1'b0);
            repeat ($urandom_range(0, 3))
               step_poll(span(0, db / 2), 1'($urandom_range(0, 1)));
            step_poll(span(1, db + lp), 1'b1);
            step_poll(span(0, lp), 1'b1);
         end
      end else if (pick < 75) begin
         // long hold through several repeat ticks
         step_poll(span(db + 1, db + lp), 1'b0);
         repeat ($urandom_range(1, 6))
            step_poll(span(lp / 2, lp + lp / 2), 1'b0);
         step_poll(span(db + 1, db + lp), 1'b1);
      end else if (pick < 90) begin
         // released, time passing
         repeat ($urandom_range(1, 3))
            step_poll(span(0, 3 * lp), 1'b1);
      end else begin
         // noise: arbitrary jumps and pin levels
         repeat ($urandom_range(1, 4))
            step_poll($urandom_range(0, 1) ? $urandom : 32'd0, 1'($urandom_range(0, 1)));
      end
   endtask

   // receiver stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);

   // request and response monitor
   always @(posedge clock) begin
      result_type  want;
      result_type  got;
      fixed_answer note;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = decode_poll(req_tdata[TIME_W-1:0], req_tdata[TIME_W]);
            note = fixed_answers.pop_front();
            if (note.typed)
               want = note.want;
            reports_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[4:0]);
            if (reports_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: response with none pending: action %0d led %0b changed %0b",
                           $time, got.key_action, got.led_on, got.level_changed);
            end else begin
               want = reports_due.pop_front();
               responses_checked++;
               if (want.key_action != ACT_NONE)
                  actions_seen++;
               if (got.key_action !== want.key_action || got.led_on !== want.led_on ||
                   got.level_changed !== want.level_changed) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"%0t: mismatch: expected action %0d led %0b changed %0b,",
                               " actual action %0d led %0b changed %0b"},
                              $time, want.key_action, want.led_on, want.level_changed,
                              got.key_action, got.led_on, got.level_changed);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("page_turn_button_gesture_decoder regression: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned target;

      // directed: disabled, taps, holds, repeat ticks, wrap and register extremes
      script.push_back(row_check(32'h0000_1000, 1'b0, ACT_NONE, 1'b0, 1'b0));
      script.push_back(row_check(32'hFFFF_FFFF, 1'b1, ACT_NONE, 1'b0, 1'b0));
      script.push_back(row_reg(CSR_ENABLE, 32'd1));
      script.push_back(row_reg(CSR_DEBOUNCE_US, 32'd100));
      script.push_back(row_reg(CSR_HOLD_TIME_US, 32'd1000));
      script.push_back(row_check(32'd1000,  1'b0, ACT_NONE,  1'b1, 1'b1));
      script.push_back(row_check(32'd1050,  1'b1, ACT_NONE,  1'b1, 1'b0));  // bounce
      script.push_back(row_check(32'd1500,  1'b1, ACT_PGDN,  1'b0, 1'b1));
      script.push_back(row_check(32'd2000,  1'b0, ACT_NONE,  1'b1, 1'b1));
      script.push_back(row_check(32'd2200,  1'b1, ACT_PGUP2, 1'b0, 1'b1));  // double tap
      script.push_back(row_check(32'd3000,  1'b0, ACT_NONE,  1'b1, 1'b1));
      script.push_back(row_check(32'd4001,  1'b0, ACT_CEND,  1'b0, 1'b0));
      script.push_back(row_check(32'd5001,  1'b0, ACT_PGUP,  1'b1, 1'b0));
      script.push_back(row_check(32'd6001,  1'b0, ACT_PGUP,  1'b0, 1'b0));  // saturated
      script.push_back(row_check(32'd6500,  1'b1, ACT_NONE,  1'b0, 1'b1));  // after hold
      script.push_back(row_check(32'd9000,  1'b0, ACT_NONE,  1'b1, 1'b1));
      script.push_back(row_check(32'd9200,  1'b1, ACT_PGDN,  1'b0, 1'b1));
      script.push_back(row_check(32'd9400,  1'b0, ACT_NONE,  1'b1, 1'b1));
      script.push_back(row_check(32'd10401, 1'b0, ACT_CHOME, 1'b0, 1'b0));
      script.push_back(row_check(32'd11401, 1'b0, ACT_PGDN,  1'b1, 1'b0));
      // zero repeat period: every later poll ticks
      script.push_back(row_reg(CSR_HOLD_TIME_US, 32'd0));
      script.push_back(row_poll(32'd11402, 1'b0));
      script.push_back(row_poll(32'd11402, 1'b0));
      script.push_back(row_reg(CSR_SPARE, 32'hFFFF_FFFF));
      // largest debounce ignores everything
      script.push_back(row_reg(CSR_DEBOUNCE_US, 32'hFFFF_FFFF));
      script.push_back(row_poll(32'hFFFF_FFFF, 1'b1));
      script.push_back(row_reg(CSR_DEBOUNCE_US, 32'd0));
      script.push_back(row_reg(CSR_HOLD_TIME_US, 32'hFFFF_FFFF));
      // timestamps across the wrap
      script.push_back(row_poll(32'hFFFF_FFFF, 1'b1));
      script.push_back(row_poll(32'h0000_0000, 1'b0));
      script.push_back(row_poll(32'h0000_0010, 1'b1));
      script.push_back(row_reg(CSR_ENABLE, 32'd0));
      script.push_back(row_poll(32'h8000_0000, 1'b0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_REG)
            write_reg(script[i].index, script[i].value);
         else
            send_poll(script[i].value, script[i].pin, script[i].typed, script[i].want);
      end

      // random gestures, three register settings per idling phase
      stamp = $urandom;
      for (int p = 0; p < 4; p++) begin
         gap_pct   = gap_plan[p];
         stall_pct = stall_plan[p];
         for (int k = 0; k < 3; k++) begin
            apply_setting(plan[p * 3 + k]);
            target = polls_sent + ((plan[p * 3 + k] == SET_DISABLED) ? 10 : CHUNK_POLLS);
            while (polls_sent < target)
               play_gesture();
         end
      end

      req_tvalid <= 1'b0;
      while (responses_checked < polls_sent)
         @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d polls over %0d register writes; %0d responses checked,",
               polls_sent, reg_writes, responses_checked);
      $display("%0d of them key actions, under four sender/receiver idling mixes",
               actions_seen);
      if (mismatches == 0 && reports_due.size() == 0)
         $display("page_turn_button_gesture_decoder regression: pass");
      else
         $display("page_turn_button_gesture_decoder regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/ptbgd_pkg.sv
hdl/ptbgd_csr.sv
hdl/ptbgd_core.sv
hdl/page_turn_button_gesture_decoder.sv
hdl/ptbgd_checker.sv
tb/tb_page_turn_button_gesture_decoder.sv
